// ----- hw/rtl/lcwd_pkg.sv -----
// lcwd_pkg: shared constants, types and the decade table for the load-cell weight block
// no dependencies; compiled first

package lcwd_pkg;

    localparam int W_WEIGHT  = 24;
    localparam int W_DIGIT   = 4;
    localparam int N_DIGITS  = 7;
    localparam int N_SHOWN   = 5;
    localparam int DIV_WIDTH = 16;

    localparam logic [DIV_WIDTH-1:0] DIV_RESET    = 16'd293;
    localparam logic [W_WEIGHT-1:0]  WEIGHT_MAX   = 24'd9999999;
    localparam logic [W_WEIGHT-1:0]  WEIGHT_LIMIT = 24'd10000000;
    localparam logic [W_DIGIT-1:0]   BLANK_CODE   = 4'd11;
    localparam logic [2:0]           LAST_DECADE  = 3'd5;

    // input item function: new sample or tare capture
    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TARE   = 1'b1
    } t_func;

    // seven digits, index 0 is millions, index 6 is units
    typedef logic [N_DIGITS-1:0][W_DIGIT-1:0] t_digits;
    // shown window, index 0 is leftmost
    typedef logic [N_SHOWN-1:0][W_DIGIT-1:0]  t_window;

    // trial subtrahend: decade value of digit idx times 2**sh
    function automatic logic [W_WEIGHT-1:0] pow_mult(input logic [2:0] idx,
                                                     input logic [1:0] sh);
        logic [W_WEIGHT-1:0] p;
        unique case (idx)
            3'd0:    p = 24'd1000000;
            3'd1:    p = 24'd100000;
            3'd2:    p = 24'd10000;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd100;
            3'd5:    p = 24'd10;
            default: p = 24'd1;
        endcase
        return p << sh;
    endfunction

endpackage

// ----- hw/rtl/lcwd_if.sv -----
// lcwd_in_if / lcwd_out_if: valid-ready channels for samples and display results
// no dependencies; field widths are given in this file

interface lcwd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [SAMPLE_BITS-1:0] raw_code;

    modport source (output valid, output func, output raw_code, input ready);
    modport sink   (input valid, input func, input raw_code, output ready);
endinterface

interface lcwd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] weight;
    logic        saturated;
    logic [3:0]  digit_one;
    logic [3:0]  digit_two;
    logic [3:0]  digit_three;
    logic [3:0]  digit_four;
    logic [3:0]  digit_five;

    modport source (output valid, output weight, output saturated, output digit_one,
                    output digit_two, output digit_three, output digit_four,
                    output digit_five, input ready);
    modport sink   (input valid, input weight, input saturated, input digit_one,
                    input digit_two, input digit_three, input digit_four,
                    input digit_five, output ready);
endinterface

// ----- hw/rtl/lcwd_alu.sv -----
// lcwd_alu: shared compare-and-subtract unit
// no dependencies

module lcwd_alu #(
    parameter int W = 24
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_ge
);
    logic borrow;

    assign {borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~borrow;
endmodule

// ----- hw/rtl/lcwd_window.sv -----
// lcwd_window: leading-zero blanking and five-digit window select
// depends on lcwd_pkg

module lcwd_window (
    input  lcwd_pkg::t_digits i_digits,
    output lcwd_pkg::t_window o_window
);
    import lcwd_pkg::*;

    logic [N_DIGITS-2:0] blank;
    t_digits             shown;

    always_comb begin
        blank[0] = (i_digits[0] == '0);
        for (int i = 1; i < N_DIGITS - 1; i++) begin
            blank[i] = (i_digits[i] == '0) && blank[i-1];
        end
        for (int i = 0; i < N_DIGITS - 1; i++) begin
            shown[i] = blank[i] ? BLANK_CODE : i_digits[i];
        end
        shown[N_DIGITS-1] = i_digits[N_DIGITS-1];

        priority if (blank[0] && blank[1]) begin
            for (int i = 0; i < N_SHOWN; i++) o_window[i] = shown[i+2];
        end else if (blank[0]) begin
            for (int i = 0; i < N_SHOWN; i++) o_window[i] = shown[i+1];
        end else begin
            for (int i = 0; i < N_SHOWN; i++) o_window[i] = shown[i];
        end
    end
endmodule

// ----- hw/rtl/load_cell_weight_to_digits.sv -----
// load_cell_weight_to_digits: tare, scale and decimal display of load-cell samples
// one job at a time: the serial divider and digit split run on one shared unit, and no new
//   input is taken until a finished job has moved into the output register; a finished job
//   holds until the output register is free
// reset (synchronous, active low): divisor 293, last reading and tare zero, idle
// depends on lcwd_pkg, lcwd_in_if, lcwd_out_if, lcwd_alu, lcwd_window

module load_cell_weight_to_digits #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lcwd_pkg::DIV_WIDTH-1:0]     i_cfg_data,
    lcwd_in_if.sink                            i_in,
    lcwd_out_if.source                         o_out
);
    import lcwd_pkg::*;

    // shared unit is wide enough for the sample difference and the weight
    localparam int AW = (SAMPLE_BITS > W_WEIGHT) ? SAMPLE_BITS : W_WEIGHT;
    localparam int CW = $clog2(SAMPLE_BITS);
    localparam logic [CW-1:0] CNT_LAST = CW'(SAMPLE_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV,
        ST_SAT,
        ST_DIGIT,
        ST_DONE
    } t_state;

    t_state                 r_state;
    logic [DIV_WIDTH-1:0]   r_scale;
    logic [SAMPLE_BITS-1:0] r_last;
    logic [SAMPLE_BITS-1:0] r_tare;

    // divider working set: quotient shifts in as dividend shifts out
    logic [SAMPLE_BITS-1:0] r_quo;
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [CW-1:0]          r_cnt;

    // digit split: remainder, decade index, trial bit, partial digit
    logic [W_WEIGHT-1:0]    r_val;
    logic [2:0]             r_dig;
    logic [1:0]             r_bit;
    logic [W_DIGIT-1:0]     r_acc;
    t_digits                r_digit;
    logic [W_WEIGHT-1:0]    r_weight;
    logic                   r_sat;

    // output register
    logic                   r_out_valid;
    logic [W_WEIGHT-1:0]    r_o_weight;
    logic                   r_o_sat;
    t_window                r_o_win;

    logic [AW-1:0]          alu_a;
    logic [AW-1:0]          alu_b;
    logic [AW-1:0]          alu_diff;
    logic                   alu_ge;
    logic [DIV_WIDTH-1:0]   eff_div;
    logic [W_WEIGHT-1:0]    n_val;
    logic [W_DIGIT-1:0]     n_acc;
    t_window                window;
    logic                   in_xfer;

    lcwd_alu #(.W(AW)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge)
    );

    lcwd_window u_window (
        .i_digits (r_digit),
        .o_window (window)
    );

    // zero divisor acts as one
    assign eff_div = (r_scale == '0) ? DIV_WIDTH'(1) : r_scale;
    assign in_xfer = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // operand steering for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            ST_DIFF: begin
                alu_a = AW'(r_last);
                alu_b = AW'(r_tare);
            end
            ST_DIV: begin
                // partial remainder with next dividend bit appended
                alu_a[DIV_WIDTH:0] = {r_rem, r_quo[SAMPLE_BITS-1]};
                alu_b = AW'(eff_div);
            end
            ST_SAT: begin
                alu_a = AW'(r_quo);
                alu_b = AW'(WEIGHT_LIMIT);
            end
            ST_DIGIT: begin
                alu_a = AW'(r_val);
                alu_b = AW'(pow_mult(r_dig, r_bit));
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // digit trial results
    always_comb begin
        n_val = alu_ge ? alu_diff[W_WEIGHT-1:0] : r_val;
        n_acc = r_acc;
        if (alu_ge) begin
            n_acc[r_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale     <= DIV_RESET;
            r_last      <= '0;
            r_tare      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_data;
            end

            // output transfer frees the register, unless a new result loads it
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.func == FUNC_TARE) begin
                            r_tare <= r_last;
                        end else begin
                            // offset-binary: flip the sign bit
                            r_last <= {~i_in.raw_code[SAMPLE_BITS-1],
                                       i_in.raw_code[SAMPLE_BITS-2:0]};
                        end
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    // net reading, clamped to zero when not above tare
                    r_quo   <= alu_ge ? alu_diff[SAMPLE_BITS-1:0] : '0;
                    r_rem   <= '0;
                    r_cnt   <= CNT_LAST;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_rem <= alu_ge ? alu_diff[DIV_WIDTH-1:0] : alu_a[DIV_WIDTH-1:0];
                    r_quo <= {r_quo[SAMPLE_BITS-2:0], alu_ge};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    r_sat    <= alu_ge;
                    r_weight <= alu_ge ? WEIGHT_MAX : W_WEIGHT'(r_quo);
                    r_val    <= alu_ge ? WEIGHT_MAX : W_WEIGHT'(r_quo);
                    r_dig    <= '0;
                    r_bit    <= 2'd3;
                    r_acc    <= '0;
                    r_state  <= ST_DIGIT;
                end
                ST_DIGIT: begin
                    // each decade tried at 8x, 4x, 2x, 1x
                    r_val <= n_val;
                    r_bit <= r_bit - 2'd1;
                    if (r_bit == 2'd0) begin
                        r_acc <= '0;
                        r_dig <= r_dig + 3'd1;
                        if (r_dig == LAST_DECADE) begin
                            // tens digit done, what is left is the units digit
                            r_digit[N_DIGITS-1:N_DIGITS-2] <= {n_val[W_DIGIT-1:0], n_acc};
                            r_state                        <= ST_DONE;
                        end else begin
                            r_digit[r_dig] <= n_acc;
                        end
                    end else begin
                        r_acc <= n_acc;
                    end
                end
                ST_DONE: begin
                    // wait for the output register to be free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_weight  <= r_weight;
                        r_o_sat     <= r_sat;
                        r_o_win     <= window;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.weight      = r_o_weight;
    assign o_out.saturated   = r_o_sat;
    assign o_out.digit_one   = r_o_win[0];
    assign o_out.digit_two   = r_o_win[1];
    assign o_out.digit_three = r_o_win[2];
    assign o_out.digit_four  = r_o_win[3];
    assign o_out.digit_five  = r_o_win[4];

    // divider invariant: partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < eff_div))
        else $error("divider remainder not below divisor");

    // after the last decade only a units value may remain
    a_units_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_val < W_WEIGHT'(10)))
        else $error("digit split left a remainder of ten or more");

    // saturation flag always pairs with the clamp value
    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (o_out.weight == WEIGHT_MAX))
        else $error("saturated result without clamped weight");

    // weight shown never exceeds seven digits
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.weight <= WEIGHT_MAX))
        else $error("result weight out of range");

    // an input transfer starts a job, so no second transfer follows directly
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("input ready while a job is running");
endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for load_cell_weight_to_digits, with a display scoreboard class
// depends on lcwd_pkg, lcwd_in_if, lcwd_out_if and the load_cell_weight_to_digits rtl

localparam logic [23:0] SIGN_FLIP = 24'h800000;

typedef struct packed {
    logic [23:0]        weight;
    logic               saturated;
    lcwd_pkg::t_window  shown;
} t_weight_display;

class display_board;
    logic [15:0]     divisor;
    logic [23:0]     reading_reg;
    logic [23:0]     tare_reg;
    t_weight_display display_due[$];
    int unsigned     fails;

    function new();
        divisor     = lcwd_pkg::DIV_RESET;
        reading_reg = '0;
        tare_reg    = '0;
        fails       = 0;
    endfunction

    function t_weight_display predict_display();
        t_weight_display e;
        logic [3:0]      dec [7];
        int unsigned     dv;
        int unsigned     quo;
        int unsigned     rest;
        int              first;
        bit              leading;
        dv          = (divisor == 0) ? 1 : divisor;
        e.weight    = '0;
        e.saturated = 1'b0;
        if (reading_reg > tare_reg) begin
            quo = (reading_reg - tare_reg) / dv;
            if (quo > lcwd_pkg::WEIGHT_MAX) begin
                e.weight    = lcwd_pkg::WEIGHT_MAX;
                e.saturated = 1'b1;
            end else begin
                e.weight = quo[23:0];
            end
        end
        rest = e.weight;
        for (int i = 6; i >= 0; i--) begin
            dec[i] = 4'(rest % 10);
            rest   = rest / 10;
        end
        // leading zeros down to the tens digit go blank
        leading = 1'b1;
        for (int i = 0; i < 6; i++) begin
            if (leading && dec[i] == 4'd0)
                dec[i] = lcwd_pkg::BLANK_CODE;
            else
                leading = 1'b0;
        end
        if (dec[0] != lcwd_pkg::BLANK_CODE)
            first = 0;
        else if (dec[1] != lcwd_pkg::BLANK_CODE)
            first = 1;
        else
            first = 2;
        for (int k = 0; k < 5; k++)
            e.shown[k] = dec[first + k];
        return e;
    endfunction

    function void take_sample(lcwd_pkg::t_func f, logic [23:0] raw);
        if (f == lcwd_pkg::FUNC_TARE)
            tare_reg = reading_reg;
        else
            reading_reg = raw ^ SIGN_FLIP;
        display_due.push_back(predict_display());
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        fails++;
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task compare_display(t_weight_display seen);
        t_weight_display want;
        if (display_due.size() == 0) begin
            report_mismatch("result with none due, weight", seen.weight, 0);
            return;
        end
        want = display_due.pop_front();
        if (seen.weight !== want.weight)
            report_mismatch("weight", seen.weight, want.weight);
        if (seen.saturated !== want.saturated)
            report_mismatch("saturated", seen.saturated, want.saturated);
        for (int k = 0; k < 5; k++) begin
            if (seen.shown[k] !== want.shown[k])
                report_mismatch($sformatf("digit %0d", k + 1), seen.shown[k], want.shown[k]);
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcwd_pkg::*;

    // cycles with no transfer on either channel before the run is called hung
    localparam int unsigned STALL_LIMIT = 3000;
    // cycles the receiver refuses results during a pressure stretch
    localparam int          HOLD_CYCLES = 400;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // calm: no idling on either side; hold_asks: bumped to start a receiver hold-off
    bit          calm        = 1'b0;
    int          hold_asks   = 0;
    int unsigned idle_cycles = 0;

    display_board sb = new();

    lcwd_in_if #(.SAMPLE_BITS(24)) in_ch();
    lcwd_out_if                    out_ch();

    load_cell_weight_to_digits #(.SAMPLE_BITS(24)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // offer one item, with random idle cycles first, and note it at its transfer
    task automatic send_item(t_func f, logic [23:0] raw);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 28)
                gap++;
            // now and then a long gap so idling lands on every step of the divider
            if ($urandom_range(0, 99) < 3)
                gap += $urandom_range(10, 90);
        end
        if (gap > 0) begin
            in_ch.valid    <= 1'b0;
            in_ch.raw_code <= 24'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= f;
        in_ch.raw_code <= raw;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        sb.take_sample(f, raw);
    endtask

    // the divisor only changes once every result due has come back
    task automatic write_divisor(logic [15:0] value);
        in_ch.valid <= 1'b0;
        while (sb.display_due.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.divisor  = value;
    endtask

    // mostly readings aimed at a chosen weight size above the current tare,
    // plus tare requests, raw noise and readings at or below the tare
    task automatic run_random_phase(logic [15:0] dv_value, int items, bit quiet, bit squeeze);
        longint unsigned base;
        longint unsigned step;
        longint unsigned span;
        longint unsigned cap;
        longint unsigned rd;
        int              roll;
        write_divisor(dv_value);
        calm = quiet;
        for (int n = 0; n < items; n++) begin
            if (squeeze && n == items / 4)
                hold_asks <= hold_asks + 1;
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_item(FUNC_TARE, 24'($urandom));
            end else if (roll < 40) begin
                send_item(FUNC_SAMPLE, 24'($urandom));
            end else begin
                base = sb.tare_reg;
                step = (sb.divisor == 0) ? 1 : sb.divisor;
                if (roll < 48) begin
                    rd = $urandom_range(0, 32'(base));
                end else begin
                    span = (64'hFFFFFF - base) / step;
                    cap  = 1;
                    repeat ($urandom_range(1, 8)) cap = cap * 10;
                    cap = cap - 1;
                    if (cap > span)
                        cap = span;
                    rd = base + $urandom_range(0, 32'(cap)) * step
                         + $urandom_range(0, 32'(step - 1));
                    if (rd > 64'hFFFFFF)
                        rd = 64'hFFFFFF;
                end
                send_item(FUNC_SAMPLE, rd[23:0] ^ SIGN_FLIP);
            end
        end
        calm = 1'b0;
    endtask

    // stimulus
    initial begin
        in_ch.valid    <= 1'b0;
        in_ch.func     <= FUNC_SAMPLE;
        in_ch.raw_code <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset divisor: tare at reset, extreme codes, readings at and below the tare
        send_item(FUNC_TARE,   24'hABCDEF);
        send_item(FUNC_SAMPLE, 24'h800000);
        send_item(FUNC_SAMPLE, 24'h000000);
        send_item(FUNC_SAMPLE, 24'h7FFFFF);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_TARE,   24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h7FFFFE);
        send_item(FUNC_SAMPLE, 24'h800001);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);

        // divisor 1: saturation edge and each display window
        write_divisor(16'd1);
        send_item(FUNC_SAMPLE, 24'h800000);
        send_item(FUNC_TARE,   24'h000000);
        send_item(FUNC_SAMPLE, 24'h7FFFFF);
        send_item(FUNC_SAMPLE, 24'd9999999 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd10000000 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd1000000 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd123456 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd7 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd100000 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd12345 ^ SIGN_FLIP);

        // zero divisor behaves as one
        write_divisor(16'd0);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h7FFFFF);

        // largest divisor
        write_divisor(16'hFFFF);
        send_item(FUNC_SAMPLE, 24'h7FFFFF);
        send_item(FUNC_SAMPLE, 24'd65534 ^ SIGN_FLIP);
        send_item(FUNC_SAMPLE, 24'd65535 ^ SIGN_FLIP);

        // random phases over a spread of divisors
        run_random_phase(16'd293,                     172, 1'b0, 1'b0);
        run_random_phase(16'd1,                       172, 1'b0, 1'b1);
        run_random_phase(16'hFFFF,                    172, 1'b0, 1'b0);
        run_random_phase(16'($urandom_range(2, 50)),  172, 1'b1, 1'b0);
        run_random_phase(16'($urandom_range(1, 65535)), 172, 1'b0, 1'b0);
        run_random_phase(16'd0,                       172, 1'b0, 1'b0);
        run_random_phase(16'($urandom_range(51, 5000)), 172, 1'b0, 1'b1);
        run_random_phase(16'd10,                      172, 1'b0, 1'b0);

        // drain, then give the block a result time to show anything stray
        in_ch.valid <= 1'b0;
        while (sb.display_due.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side: random ready, long hold-offs on request, none while calm
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_weight_display seen;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.weight    = out_ch.weight;
            seen.saturated = out_ch.saturated;
            seen.shown[0]  = out_ch.digit_one;
            seen.shown[1]  = out_ch.digit_two;
            seen.shown[2]  = out_ch.digit_three;
            seen.shown[3]  = out_ch.digit_four;
            seen.shown[4]  = out_ch.digit_five;
            sb.compare_display(seen);
        end
    end

    // watchdog: too long without any transfer means the block is stuck
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
